// ----- sv/qpm_pkg.sv -----
// Shared types and fixed-point helpers for the quaternion pose-to-matrix unit.
// No dependencies.
package qpm_pkg;
  localparam int VW = 48;
  localparam int FB = 24;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE = VW'(64'sd1 <<< FB);

  typedef enum logic [2:0] {
    K_IDENT = 3'd0, K_TRANS = 3'd1, K_ROT = 3'd2, K_ROTS = 3'd3, K_FULL = 3'd4
  } kind_e;

  typedef logic signed [VW-1:0] val_t;

  // Queue entry from front to back: one compute request.
  typedef struct packed {
    logic [2:0] kind;
  } req_t;

  // Saturating add.
  function automatic val_t sadd(val_t a, val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) sadd = s[VW] ? VMIN : VMAX;
    else sadd = s[VW-1:0];
  endfunction

  function automatic val_t sneg(val_t a);
    sneg = (a == VMIN) ? VMAX : -a;
  endfunction
endpackage

// ----- sv/qpm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/qpm_mul.sv -----
// Saturating signed fixed-point multiplier built from four partial products of 32-bit low and 16-bit high halves.
// Depends on qpm_pkg.
module qpm_mul import qpm_pkg::*; (
  input  logic clk_i,
  input  val_t a_i,
  input  val_t b_i,
  output val_t p_o
);
  logic        neg_q;
  logic [63:0] ll_q, lh_q, hl_q, hh_q;
  logic [47:0] ma, mb;
  logic [127:0] prod;
  logic [127:0] qv;
  logic [48:0] lim;

  assign ma = a_i[VW-1] ? 48'(-a_i) : 48'(a_i);
  assign mb = b_i[VW-1] ? 48'(-b_i) : 48'(b_i);

  // Stage 1: partial products
  always_ff @(posedge clk_i) begin
    neg_q <= a_i[VW-1] ^ b_i[VW-1];
    ll_q  <= 64'(ma[31:0]) * 64'(mb[31:0]);
    lh_q  <= 64'(ma[31:0]) * 64'(mb[47:32]);
    hl_q  <= 64'(ma[47:32]) * 64'(mb[31:0]);
    hh_q  <= 64'(ma[47:32]) * 64'(mb[47:32]);
  end

  // Stage 2: sum, scale, saturate
  assign prod = 128'(ll_q) + (128'(lh_q) << 32) + (128'(hl_q) << 32) + (128'(hh_q) << 64);
  assign qv   = prod >> FB;
  assign lim  = neg_q ? 49'(VMAX) + 49'd1 : 49'(VMAX);

  always_ff @(posedge clk_i) begin
    if (qv > 128'(lim)) p_o <= neg_q ? VMIN : VMAX;
    else if (neg_q) p_o <= (qv[48:0] == lim) ? VMIN : -val_t'(qv[47:0]);
    else p_o <= val_t'(qv[47:0]);
  end
endmodule

// ----- sv/qpm_front.sv -----
// Front end: accepts items, writes loads to the store, queues compute requests.
// Depends on qpm_pkg.
module qpm_front import qpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [3:0] slot_i,
  input  val_t       value_i,
  input  logic [2:0] kind_i,
  output logic       we_o,
  output logic [3:0] waddr_o,
  output val_t       wdata_o,
  output logic       req_valid_o,
  output req_t       req_o,
  input  logic       req_ready_i
);
  // Two-entry queue of compute requests
  req_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       acc, push, pop;

  // Loads wait while requests are pending so they never overwrite live slots
  assign in_ready_o = cmd_i ? (cnt_q != 2'd2) : (cnt_q == 2'd0 && req_ready_i);
  assign acc  = in_valid_i && in_ready_o;
  assign push = acc && cmd_i;
  assign pop  = req_valid_o && req_ready_i;
  assign we_o = acc && !cmd_i;
  assign waddr_o = slot_i;
  assign wdata_o = value_i;
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= '{kind: kind_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q == 2'd2 |-> !push || pop;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> cnt_q == 2'd0) else $error("load while busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad count");
endmodule

// ----- sv/qpm_back.sv -----
// Back end: sequencer that reads the store, runs the shared multiplier and emits elements.
// Depends on qpm_pkg, qpm_ram, qpm_mul.
module qpm_back import qpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] tol_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  val_t        wdata_i,
  input  logic        req_valid_i,
  input  req_t        req_i,
  output logic        req_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  idx_o,
  output val_t        val_o,
  output logic        not_unit_o,
  output logic        last_o
);
  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_CHK, S_EMIT} state_e;

  state_e     st_q;
  logic [2:0] kind_q;
  logic [4:0] cnt_q;       // read / multiply step counter
  logic [3:0] k_q;         // element being emitted
  val_t       v_q [16];    // scaled rotation elements by matrix position
  val_t       sl_q [16];   // slot copy
  val_t       pr_q [10];   // xx yy zz ww xy xz yz xw yw zw
  val_t       el_q [9];    // rotation elements before scale
  logic [3:0] raddr;
  val_t       rdata, ma, mb, mp;
  logic       sk_full_q;

  qpm_ram #(.Width(VW), .Depth(16)) u_store (
    .clk_i, .we_i, .waddr_i, .wdata_i, .raddr_i(raddr), .rdata_o(rdata));
  qpm_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  assign raddr = cnt_q[3:0];
  assign req_ready_o = st_q == S_IDLE;

  // Multiplier operand schedule: ten quaternion products, then nine scalings
  always_comb begin
    ma = '0; mb = '0;
    case (cnt_q)
      5'd0: begin ma = sl_q[3]; mb = sl_q[3]; end
      5'd1: begin ma = sl_q[4]; mb = sl_q[4]; end
      5'd2: begin ma = sl_q[5]; mb = sl_q[5]; end
      5'd3: begin ma = sl_q[6]; mb = sl_q[6]; end
      5'd4: begin ma = sl_q[3]; mb = sl_q[4]; end
      5'd5: begin ma = sl_q[3]; mb = sl_q[5]; end
      5'd6: begin ma = sl_q[4]; mb = sl_q[5]; end
      5'd7: begin ma = sl_q[3]; mb = sl_q[6]; end
      5'd8: begin ma = sl_q[4]; mb = sl_q[6]; end
      5'd9: begin ma = sl_q[5]; mb = sl_q[6]; end
      default: begin
        if (cnt_q >= 5'd12 && cnt_q <= 5'd20) begin
          ma = el_q[4'(cnt_q - 5'd12)];
          mb = (kind_q == K_ROTS) ? sl_q[7] : ONE;
        end
      end
    endcase
  end

  // Norm deviation from the squared products, and its magnitude
  val_t dev, mag;
  always_comb begin
    dev = sadd(sadd(sadd(sadd(pr_q[0], pr_q[1]), pr_q[2]), pr_q[3]), sneg(ONE));
    mag = dev[VW-1] ? -dev : dev;
  end

  // Output register load: an element or the error word, when the slot is free
  logic chk_fail, fire;
  assign chk_fail = mag >= val_t'(tol_i);
  assign fire = (!out_valid_o || out_ready_i) &&
                (st_q == S_EMIT || (st_q == S_CHK && chk_fail));

  // Element for the current position
  val_t cur;
  always_comb begin
    cur = (k_q == 4'd0 || k_q == 4'd5 || k_q == 4'd10 || k_q == 4'd15) ? ONE : '0;
    if (kind_q == K_FULL) begin
      if (k_q < 4'd12) cur = sl_q[k_q];
      else if (k_q == 4'd15) cur = sl_q[12];
      else cur = sl_q[k_q + 4'd1];
    end else if (kind_q == K_TRANS || kind_q == K_ROT || kind_q == K_ROTS) begin
      if (k_q >= 4'd12 && k_q <= 4'd14) cur = sl_q[k_q - 4'd12];
      if (kind_q != K_TRANS && k_q <= 4'd10 && k_q != 4'd3 && k_q != 4'd7)
        cur = v_q[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; out_valid_o <= 1'b0; cnt_q <= '0; k_q <= '0;
      kind_q <= '0; sk_full_q <= 1'b0;
    end else begin
      if (fire) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      case (st_q)
        S_IDLE: if (req_valid_i) begin
          kind_q <= req_i.kind; cnt_q <= '0; st_q <= S_LOAD;
        end
        // One slot per cycle; read data is registered, so each slot is stored from the previous address
        S_LOAD: begin
          if (cnt_q != 5'd0) sl_q[4'(cnt_q - 5'd1)] <= rdata;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) begin
            cnt_q <= '0; k_q <= '0;
            st_q <= (kind_q == K_ROT || kind_q == K_ROTS) ? S_MUL : S_EMIT;
          end
        end
        // Products are captured from the pipelined multiplier output, offset from their operand steps
        S_MUL: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q >= 5'd2 && cnt_q <= 5'd11) pr_q[4'(cnt_q - 5'd2)] <= mp;
          if (cnt_q == 5'd11) st_q <= S_CHK;
          if (cnt_q >= 5'd14 && cnt_q <= 5'd22) begin
            case (cnt_q)
              5'd14: v_q[0] <= mp; 5'd15: v_q[1] <= mp; 5'd16: v_q[2] <= mp;
              5'd17: v_q[4] <= mp; 5'd18: v_q[5] <= mp; 5'd19: v_q[6] <= mp;
              5'd20: v_q[8] <= mp; 5'd21: v_q[9] <= mp;
              default: v_q[10] <= mp;
            endcase
          end
          if (cnt_q == 5'd22) st_q <= S_EMIT;
        end
        // Norm check, then form the unscaled rotation terms
        S_CHK: begin
          if (chk_fail) begin
            if (fire) begin
              idx_o <= '0; val_o <= '0;
              not_unit_o <= 1'b1; last_o <= 1'b1; st_q <= S_IDLE;
            end
          end else begin
            el_q[0] <= sadd(ONE, sneg(sadd(sadd(pr_q[1], pr_q[2]), sadd(pr_q[1], pr_q[2]))));
            el_q[1] <= sadd(sadd(pr_q[4], pr_q[9]), sadd(pr_q[4], pr_q[9]));
            el_q[2] <= sadd(sadd(pr_q[5], sneg(pr_q[8])), sadd(pr_q[5], sneg(pr_q[8])));
            el_q[3] <= sadd(sadd(pr_q[4], sneg(pr_q[9])), sadd(pr_q[4], sneg(pr_q[9])));
            el_q[4] <= sadd(ONE, sneg(sadd(sadd(pr_q[0], pr_q[2]), sadd(pr_q[0], pr_q[2]))));
            el_q[5] <= sadd(sadd(pr_q[6], pr_q[7]), sadd(pr_q[6], pr_q[7]));
            el_q[6] <= sadd(sadd(pr_q[5], pr_q[8]), sadd(pr_q[5], pr_q[8]));
            el_q[7] <= sadd(sadd(pr_q[6], sneg(pr_q[7])), sadd(pr_q[6], sneg(pr_q[7])));
            el_q[8] <= sadd(ONE, sneg(sadd(sadd(pr_q[0], pr_q[1]), sadd(pr_q[0], pr_q[1]))));
            cnt_q <= 5'd12; st_q <= S_MUL;
          end
        end
        // One element per free output slot
        S_EMIT: if (fire) begin
          idx_o <= k_q; val_o <= cur;
          not_unit_o <= 1'b0; last_o <= k_q == 4'd15;
          k_q <= k_q + 4'd1;
          if (k_q == 4'd15) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
      sk_full_q <= out_valid_o;
    end
  end

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(idx_o))
    else $error("result dropped");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !not_unit_o |-> idx_o == 4'd15) else $error("bad last");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_unit_o |-> last_o && idx_o == 4'd0) else $error("bad error word");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> st_q == S_IDLE || sk_full_q || !sk_full_q) else $error("ready");
endmodule

// ----- sv/quaternion_pose_to_matrix_unit.sv -----
// Top level of the quaternion pose-to-matrix unit.
// Depends on qpm_pkg, qpm_front, qpm_back.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: slot[3:0], value[51:4]; tuser: cmd[0], transform_kind[3:1]
// m_axis  | out | tdata: element_index[3:0], element_value[51:4]; tuser: not_unit; tlast
// cfg     | in  | unit_tolerance
//
// A load word is written to the store. A compute word leaves the queue, then all 16 slots
// are read; rotation kinds form products on the shared two-stage multiplier, check the norm
// and scale; 16 words then go out one per cycle while the output is ready, or one not_unit
// word if the check fails. Reset clears all control state; the store holds garbage until
// written. The output register lets the front accept compute words while results wait.
module quaternion_pose_to_matrix_unit import qpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // slot, value
  input  logic [3:0]  s_axis_tuser,   // cmd, transform_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // element_index, element_value
  output logic        m_axis_tuser,   // not_unit
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  logic [15:0] tol_q;
  logic        we, rv, rr;
  logic [3:0]  wa, idx;
  val_t        wd, ev;
  req_t        rq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= 16'd168;
    else if (cfg_we_i) tol_q <= cfg_wdata_i;
  end

  qpm_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser[0]), .slot_i(s_axis_tdata[3:0]), .value_i(s_axis_tdata[51:4]),
    .kind_i(s_axis_tuser[3:1]), .we_o(we), .waddr_o(wa), .wdata_o(wd),
    .req_valid_o(rv), .req_o(rq), .req_ready_i(rr));

  qpm_back u_back (
    .clk_i, .rst_ni, .tol_i(tol_q), .we_i(we), .waddr_i(wa), .wdata_i(wd),
    .req_valid_i(rv), .req_i(rq), .req_ready_o(rr),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .idx_o(idx), .val_o(ev),
    .not_unit_o(m_axis_tuser), .last_o(m_axis_tlast));

  assign m_axis_tdata = {4'd0, ev, idx};
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for quaternion_pose_to_matrix_unit.
// Depends on qpm_pkg and the unit RTL; predicts each output word and compares in order.
module tb;
  import qpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [3:0] slot;
    val_t       value;
    logic [2:0] kind;
  } pose_word_t;

  typedef struct packed {
    logic [3:0] index;
    val_t       value;
    logic       not_unit;
    logic       last;
  } elem_word_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [3:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  quaternion_pose_to_matrix_unit DUT (.*);

  pose_word_t pending_q[$];
  elem_word_t expected_q[$];
  val_t       slot_mirror[16];
  logic [15:0] tol_mirror;
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_phase = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Fixed-point multiply: truncate magnitude, then saturate.
  function automatic val_t fx_mul(val_t a, val_t b);
    logic [95:0] ma, mb, mp;
    logic [95:0] q, lim;
    logic neg;
    neg = a[VW-1] ^ b[VW-1];
    ma = a[VW-1] ? 96'(-$signed({{48{a[VW-1]}}, a})) : 96'(a);
    mb = b[VW-1] ? 96'(-$signed({{48{b[VW-1]}}, b})) : 96'(b);
    mp = ma * mb;
    q = mp >> FB;
    lim = neg ? 96'(VMAX) + 1 : 96'(VMAX);
    if (q > lim) return neg ? VMIN : VMAX;
    return neg ? val_t'(-q) : val_t'(q);
  endfunction

  function automatic val_t dbl(val_t a);
    return sadd(a, a);
  endfunction

  // Append one expected word.
  function automatic void expect_word(elem_word_t e);
    expected_q = {expected_q, e};
  endfunction

  // Apply one input word to the mirror and queue its expected elements.
  function automatic void predict_pose(pose_word_t w);
    val_t m[16];
    val_t x, y, z, v, s, xx, yy, zz, vv, xy, xz, yz, xw, yw, zw, dev;
    logic [47:0] mag;
    elem_word_t e;
    if (w.cmd == CMD_LOAD) begin
      slot_mirror[w.slot] = w.value;
      return;
    end
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONE : '0;
    if (w.kind == K_FULL) begin
      for (int k = 0; k < 12; k++) m[k] = slot_mirror[k];
      for (int k = 0; k < 3; k++) m[12+k] = slot_mirror[13+k];
      m[15] = slot_mirror[12];
    end else if (w.kind inside {K_TRANS, K_ROT, K_ROTS}) begin
      for (int k = 0; k < 3; k++) m[12+k] = slot_mirror[k];
      if (w.kind != K_TRANS) begin
        x = slot_mirror[3]; y = slot_mirror[4]; z = slot_mirror[5]; v = slot_mirror[6];
        s = (w.kind == K_ROTS) ? slot_mirror[7] : ONE;
        xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z); vv = fx_mul(v, v);
        xy = fx_mul(x, y); xz = fx_mul(x, z); yz = fx_mul(y, z);
        xw = fx_mul(x, v); yw = fx_mul(y, v); zw = fx_mul(z, v);
        dev = sadd(sadd(sadd(sadd(xx, yy), zz), vv), sneg(ONE));
        mag = dev[VW-1] ? 48'(-dev) : 48'(dev);
        if (mag >= 48'(tol_mirror)) begin
          e = '{index: 4'd0, value: '0, not_unit: 1'b1, last: 1'b1};
          expect_word(e);
          return;
        end
        m[0]  = fx_mul(sadd(ONE, sneg(dbl(sadd(yy, zz)))), s);
        m[1]  = fx_mul(dbl(sadd(xy, zw)), s);
        m[2]  = fx_mul(dbl(sadd(xz, sneg(yw))), s);
        m[4]  = fx_mul(dbl(sadd(xy, sneg(zw))), s);
        m[5]  = fx_mul(sadd(ONE, sneg(dbl(sadd(xx, zz)))), s);
        m[6]  = fx_mul(dbl(sadd(yz, xw)), s);
        m[8]  = fx_mul(dbl(sadd(xz, yw)), s);
        m[9]  = fx_mul(dbl(sadd(yz, sneg(xw))), s);
        m[10] = fx_mul(sadd(ONE, sneg(dbl(sadd(xx, yy)))), s);
      end
    end
    for (int k = 0; k < 16; k++) begin
      e = '{index: 4'(k), value: m[k], not_unit: 1'b0, last: (k == 15)};
      expect_word(e);
    end
  endfunction

  // Driver: presents queued words, random gaps except in the quiet phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) predict_pose(pending_q.pop_front());
        if (pending_q.size() > 0 && (quiet_phase || $urandom_range(99) >= 13)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'd0, pending_q[0].value, pending_q[0].slot};
          s_axis_tuser  <= {pending_q[0].kind, pending_q[0].cmd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output word with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_phase || ($urandom_range(99) >= 13);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, actual tdata=%h tuser=%b tlast=%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          elem_word_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata[3:0] !== e.index || m_axis_tdata[51:4] !== e.value ||
              m_axis_tuser !== e.not_unit || m_axis_tlast !== e.last) begin
            $display("%0t: mismatch, expected idx=%0d val=%h nu=%b last=%b",
                     $time, e.index, e.value, e.not_unit, e.last);
            $display("%0t:           actual   idx=%0d val=%h nu=%b last=%b",
                     $time, m_axis_tdata[3:0], m_axis_tdata[51:4],
                     m_axis_tuser, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (pending_q.size() > 0 || expected_q.size() > 0 || s_axis_tvalid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void push_load(int slot, val_t v);
    pose_word_t w;
    w = '{cmd: CMD_LOAD, slot: 4'(slot), value: v, kind: 3'($urandom_range(7))};
    pending_q = {pending_q, w};
  endfunction

  function automatic void push_compute(logic [2:0] kind);
    pose_word_t w;
    w = '{cmd: CMD_COMPUTE, slot: 4'($urandom), value: val_t'({$urandom, $urandom}),
          kind: kind};
    pending_q = {pending_q, w};
  endfunction

  function automatic val_t rand_val();
    case ($urandom_range(5))
      0: return VMAX;
      1: return VMIN;
      2: return val_t'($signed($urandom_range(4000)) - 2000) <<< 12;
      default: return val_t'({$urandom, $urandom});
    endcase
  endfunction

  // Near-unit quaternion with small perturbation.
  function automatic void push_quat();
    val_t c[4];
    int pick;
    pick = $urandom_range(3);
    for (int i = 0; i < 4; i++) c[i] = '0;
    c[pick] = ($urandom_range(1) ? ONE : -ONE);
    c[pick] = c[pick] + val_t'($signed($urandom_range(200)) - 100);
    c[(pick + 1) % 4] = val_t'($signed($urandom_range(8000)) - 4000);
    if ($urandom_range(3) == 0) begin
      c[0] = 48'sd8388608; c[1] = -48'sd8388608; c[2] = 48'sd8388608; c[3] = 48'sd8388608;
    end
    for (int i = 0; i < 4; i++) push_load(3 + i, c[i]);
  endfunction

  task automatic drain_and_settle();
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [15:0] t);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_mirror = t;
  endtask

  initial begin
    logic [15:0] tols[4];
    tols = '{16'd168, 16'd0, 16'd65535, 16'd4000};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    tol_mirror = 16'd168;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill every slot, all kinds, extremes, failed unit check.
    for (int i = 0; i < 16; i++) push_load(i, (i % 2) ? VMAX : VMIN);
    push_compute(K_FULL);
    push_compute(K_TRANS);
    push_compute(K_ROT);
    push_compute(3'd5);
    push_load(6, ONE);
    for (int i = 3; i < 6; i++) push_load(i, '0);
    push_compute(K_ROTS);
    push_compute(K_IDENT);
    drain_and_settle();

    // Random phases across tolerance settings.
    for (int ph = 0; ph < 4; ph++) begin
      set_tolerance(tols[ph]);
      quiet_phase = (ph == 2);
      for (int n = 0; n < 31; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: push_quat();
          4: push_load($urandom_range(15), rand_val());
          5: push_load($urandom_range(7), rand_val());
          default: push_compute(3'($urandom_range(7)));
        endcase
      end
      push_compute(K_ROTS);
      drain_and_settle();
    end
    quiet_phase = 0;

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
